@@ design/gpioed_pkg.sv @@
// Shared types and constants for the GPIO register block with event detection.
package gpioed_pkg;

  // Fixed widths of the pin and bus fields
  localparam int IO_W   = 54;
  localparam int WORD_W = 32;
  localparam int WIDX_W = 6;

  // Beat function codes
  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_TICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Register word offsets
  localparam logic [WIDX_W-1:0] W_FSEL_LAST = 6'd5;
  localparam logic [WIDX_W-1:0] W_SET0      = 6'd7;
  localparam logic [WIDX_W-1:0] W_SET1      = 6'd8;
  localparam logic [WIDX_W-1:0] W_CLR0      = 6'd10;
  localparam logic [WIDX_W-1:0] W_CLR1      = 6'd11;
  localparam logic [WIDX_W-1:0] W_LEV0      = 6'd13;
  localparam logic [WIDX_W-1:0] W_LEV1      = 6'd14;
  localparam logic [WIDX_W-1:0] W_EDS0      = 6'd16;
  localparam logic [WIDX_W-1:0] W_EDS1      = 6'd17;
  localparam logic [WIDX_W-1:0] W_REN0      = 6'd19;
  localparam logic [WIDX_W-1:0] W_REN1      = 6'd20;
  localparam logic [WIDX_W-1:0] W_FEN0      = 6'd22;
  localparam logic [WIDX_W-1:0] W_FEN1      = 6'd23;
  localparam logic [WIDX_W-1:0] W_HEN0      = 6'd25;
  localparam logic [WIDX_W-1:0] W_HEN1      = 6'd26;
  localparam logic [WIDX_W-1:0] W_LEN0      = 6'd28;
  localparam logic [WIDX_W-1:0] W_LEN1      = 6'd29;
  localparam logic [WIDX_W-1:0] W_PUD       = 6'd37;
  localparam logic [WIDX_W-1:0] W_PUDCLK0   = 6'd38;
  localparam logic [WIDX_W-1:0] W_PUDCLK1   = 6'd39;

  // Pins per function select word and field codes
  localparam int          FSEL_PER_WORD = 10;
  localparam int          FSEL_WORDS    = 6;
  localparam logic [2:0]  FSEL_OUT      = 3'd1;
  localparam logic [1:0]  PULL_DOWN     = 2'd1;
  localparam logic [1:0]  PULL_UP       = 2'd2;

  // One input beat
  typedef struct packed {
    func_t               func;
    logic [WIDX_W-1:0]   word_index;
    logic [WORD_W-1:0]   write_data;
    logic [IO_W-1:0]     pin_levels;
  } op_t;

  // One result beat
  typedef struct packed {
    logic [WORD_W-1:0]   read_data;
    logic [IO_W-1:0]     drive_levels;
    logic [IO_W-1:0]     drive_enable;
    logic [IO_W-1:0]     pull_up_mask;
    logic [IO_W-1:0]     pull_down_mask;
    logic                event_pending;
  } res_t;

endpackage

@@ design/gpio_register_block_edge_detect_unit.sv @@
// A beat is taken into the input register, applied to the register file as it moves on, and
// its result is held in the result register. Throughput: one beat per cycle while out_stall
// is low; the register file updates between the input register and the result register.
// Reset (synchronous, active low) empties both registers and clears all GPIO state:
// every pin input, latches, enables, event status and pulls at zero.
module gpio_register_block_edge_detect_unit #(
  parameter int PINS = 54
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic [gpioed_pkg::WIDX_W-1:0] in_word_index,
  input  logic [gpioed_pkg::WORD_W-1:0] in_write_data,
  input  logic [gpioed_pkg::IO_W-1:0]   in_pin_levels,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gpioed_pkg::WORD_W-1:0] out_read_data,
  output logic [gpioed_pkg::IO_W-1:0]   out_drive_levels,
  output logic [gpioed_pkg::IO_W-1:0]   out_drive_enable,
  output logic [gpioed_pkg::IO_W-1:0]   out_pull_up_mask,
  output logic [gpioed_pkg::IO_W-1:0]   out_pull_down_mask,
  output logic                          out_event_pending
);

  logic             in_vld_r;
  gpioed_pkg::op_t  in_op_r;
  logic             out_vld_r;
  gpioed_pkg::res_t out_res_r;
  gpioed_pkg::res_t res;
  logic             adv;
  logic             in_acc;

  // Stage advances when the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  gpioed_regs #(.PINS(PINS)) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .apply (adv),
    .op    (in_op_r),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op_r.func       <= gpioed_pkg::func_t'(in_func);
      in_op_r.word_index <= in_word_index;
      in_op_r.write_data <= in_write_data;
      in_op_r.pin_levels <= in_pin_levels;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_read_data      = out_res_r.read_data;
  assign out_drive_levels   = out_res_r.drive_levels;
  assign out_drive_enable   = out_res_r.drive_enable;
  assign out_pull_up_mask   = out_res_r.pull_up_mask;
  assign out_pull_down_mask = out_res_r.pull_down_mask;
  assign out_event_pending  = out_res_r.event_pending;

  // Stall only while a beat sits in the input register
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with empty input register");

  // An applied beat always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("applied beat lost before result register");

  // Only bus reads return data
  a_read_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_op_r.func != gpioed_pkg::FUNC_READ) |=> (out_read_data == '0))
    else $error("non-read beat returned read data");

  // A waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> !adv)
    else $error("stalled result overwritten");

endmodule

@@ design/gpioed_regs.sv @@
// GPIO register file: bus read/write decode, pin sampling and event detection.
module gpioed_regs #(
  parameter int PINS = 54
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             apply,
  input  gpioed_pkg::op_t  op,
  output gpioed_pkg::res_t res
);

  // Architectural state
  logic [2:0]      fsel_r  [PINS];
  logic [2:0]      fsel_nxt[PINS];
  logic [1:0]      pull_r  [PINS];
  logic [1:0]      pull_nxt[PINS];
  logic [PINS-1:0] latch_r, latch_nxt;
  logic [PINS-1:0] lev_r, lev_nxt;
  logic [PINS-1:0] eds_r, eds_nxt;
  logic [PINS-1:0] ren_r, ren_nxt;
  logic [PINS-1:0] fen_r, fen_nxt;
  logic [PINS-1:0] hen_r, hen_nxt;
  logic [PINS-1:0] len_r, len_nxt;
  logic [1:0]      pud_r, pud_nxt;

  logic                          wr;
  logic [gpioed_pkg::WORD_W-1:0] fsel_word [gpioed_pkg::FSEL_WORDS];
  logic [PINS-1:0]               pudclk_bits;
  logic [PINS-1:0]               now_lv;
  logic [PINS-1:0]               hits;
  logic [63:0]                   lv64;
  logic [PINS-1:0]               en_v, up_v, dn_v;
  logic [63:0]                   latch64, en64, up64, dn64;
  logic [gpioed_pkg::WORD_W-1:0] rd;

  // Place a 32-bit word into the low or high pin group
  function automatic logic [PINS-1:0] spread(input logic [31:0] d, input logic hi);
    logic [63:0] x;
    x = hi ? {d, 32'h0} : {32'h0, d};
    return x[PINS-1:0];
  endfunction

  // Replace one pin group, keep the other
  function automatic logic [PINS-1:0] replace_half(input logic [PINS-1:0] old,
                                                   input logic [31:0] d,
                                                   input logic hi);
    logic [63:0] x;
    x = 64'(old);
    if (hi) x[63:32] = d;
    else    x[31:0]  = d;
    return x[PINS-1:0];
  endfunction

  // Read one pin group as a word
  function automatic logic [31:0] half_of(input logic [PINS-1:0] v, input logic hi);
    logic [63:0] x;
    x = 64'(v);
    return hi ? x[63:32] : x[31:0];
  endfunction

  assign wr = apply && (op.func == gpioed_pkg::FUNC_WRITE);

  // Function select readback words and per-pin select writes
  for (genvar w = 0; w < gpioed_pkg::FSEL_WORDS; w++) begin : g_fword
    for (genvar k = 0; k < gpioed_pkg::FSEL_PER_WORD; k++) begin : g_fslot
      localparam int P = w * gpioed_pkg::FSEL_PER_WORD + k;
      if (P < PINS) begin : g_live
        assign fsel_word[w][3*k +: 3] = fsel_r[P];
      end else begin : g_dead
        assign fsel_word[w][3*k +: 3] = 3'd0;
      end
    end
    assign fsel_word[w][31:30] = 2'd0;
  end

  for (genvar p = 0; p < PINS; p++) begin : g_pin
    localparam int PW = p / gpioed_pkg::FSEL_PER_WORD;
    localparam int PK = p % gpioed_pkg::FSEL_PER_WORD;
    always_comb begin
      fsel_nxt[p] = fsel_r[p];
      if (wr && op.word_index == gpioed_pkg::WIDX_W'(PW)) begin
        fsel_nxt[p] = op.write_data[3*PK +: 3];
      end
    end
    // Pull clock copies the control value into the pulsed pins
    always_comb begin
      pull_nxt[p] = pudclk_bits[p] ? pud_r : pull_r[p];
    end
    assign en_v[p] = (fsel_nxt[p] == gpioed_pkg::FSEL_OUT);
    assign up_v[p] = (pull_nxt[p] == gpioed_pkg::PULL_UP);
    assign dn_v[p] = (pull_nxt[p] == gpioed_pkg::PULL_DOWN);
  end

  always_comb begin
    pudclk_bits = '0;
    if (wr && op.word_index == gpioed_pkg::W_PUDCLK0) pudclk_bits = spread(op.write_data, 1'b0);
    if (wr && op.word_index == gpioed_pkg::W_PUDCLK1) pudclk_bits = spread(op.write_data, 1'b1);
  end

  // Tick detection: edges against the previous sample, levels against enables
  assign lv64   = 64'(op.pin_levels);
  assign now_lv = lv64[PINS-1:0];
  assign hits   = (~lev_r & now_lv & ren_r) | (lev_r & ~now_lv & fen_r)
                | (now_lv & hen_r) | (~now_lv & len_r);

  // Next-state decode for word registers
  always_comb begin
    latch_nxt = latch_r;
    lev_nxt   = lev_r;
    eds_nxt   = eds_r;
    ren_nxt   = ren_r;
    fen_nxt   = fen_r;
    hen_nxt   = hen_r;
    len_nxt   = len_r;
    pud_nxt   = pud_r;
    if (apply) begin
      case (op.func)
        gpioed_pkg::FUNC_WRITE: begin
          case (op.word_index)
            gpioed_pkg::W_SET0: latch_nxt = latch_r | spread(op.write_data, 1'b0);
            gpioed_pkg::W_SET1: latch_nxt = latch_r | spread(op.write_data, 1'b1);
            gpioed_pkg::W_CLR0: latch_nxt = latch_r & ~spread(op.write_data, 1'b0);
            gpioed_pkg::W_CLR1: latch_nxt = latch_r & ~spread(op.write_data, 1'b1);
            gpioed_pkg::W_EDS0: eds_nxt = eds_r & ~spread(op.write_data, 1'b0);
            gpioed_pkg::W_EDS1: eds_nxt = eds_r & ~spread(op.write_data, 1'b1);
            gpioed_pkg::W_REN0: ren_nxt = replace_half(ren_r, op.write_data, 1'b0);
            gpioed_pkg::W_REN1: ren_nxt = replace_half(ren_r, op.write_data, 1'b1);
            gpioed_pkg::W_FEN0: fen_nxt = replace_half(fen_r, op.write_data, 1'b0);
            gpioed_pkg::W_FEN1: fen_nxt = replace_half(fen_r, op.write_data, 1'b1);
            gpioed_pkg::W_HEN0: hen_nxt = replace_half(hen_r, op.write_data, 1'b0);
            gpioed_pkg::W_HEN1: hen_nxt = replace_half(hen_r, op.write_data, 1'b1);
            gpioed_pkg::W_LEN0: len_nxt = replace_half(len_r, op.write_data, 1'b0);
            gpioed_pkg::W_LEN1: len_nxt = replace_half(len_r, op.write_data, 1'b1);
            gpioed_pkg::W_PUD:  pud_nxt = op.write_data[1:0];
            default: ;
          endcase
        end
        gpioed_pkg::FUNC_TICK: begin
          eds_nxt = eds_r | hits;
          lev_nxt = now_lv;
        end
        default: ;
      endcase
    end
  end

  // Read mux, from the state before this beat
  always_comb begin
    rd = '0;
    if (op.func == gpioed_pkg::FUNC_READ) begin
      if (op.word_index <= gpioed_pkg::W_FSEL_LAST) begin
        rd = fsel_word[op.word_index[2:0]];
      end else begin
        case (op.word_index)
          gpioed_pkg::W_LEV0: rd = half_of(lev_r, 1'b0);
          gpioed_pkg::W_LEV1: rd = half_of(lev_r, 1'b1);
          gpioed_pkg::W_EDS0: rd = half_of(eds_r, 1'b0);
          gpioed_pkg::W_EDS1: rd = half_of(eds_r, 1'b1);
          gpioed_pkg::W_REN0: rd = half_of(ren_r, 1'b0);
          gpioed_pkg::W_REN1: rd = half_of(ren_r, 1'b1);
          gpioed_pkg::W_FEN0: rd = half_of(fen_r, 1'b0);
          gpioed_pkg::W_FEN1: rd = half_of(fen_r, 1'b1);
          gpioed_pkg::W_HEN0: rd = half_of(hen_r, 1'b0);
          gpioed_pkg::W_HEN1: rd = half_of(hen_r, 1'b1);
          gpioed_pkg::W_LEN0: rd = half_of(len_r, 1'b0);
          gpioed_pkg::W_LEN1: rd = half_of(len_r, 1'b1);
          gpioed_pkg::W_PUD:  rd = {30'd0, pud_r};
          default:            rd = '0;
        endcase
      end
    end
  end

  // Result beat: read word plus post-update pin views
  assign latch64 = 64'(latch_nxt);
  assign en64    = 64'(en_v);
  assign up64    = 64'(up_v);
  assign dn64    = 64'(dn_v);

  assign res.read_data      = rd;
  assign res.drive_levels   = latch64[gpioed_pkg::IO_W-1:0];
  assign res.drive_enable   = en64[gpioed_pkg::IO_W-1:0];
  assign res.pull_up_mask   = up64[gpioed_pkg::IO_W-1:0];
  assign res.pull_down_mask = dn64[gpioed_pkg::IO_W-1:0];
  assign res.event_pending  = |eds_nxt;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PINS; i++) begin
        fsel_r[i] <= '0;
        pull_r[i] <= '0;
      end
      latch_r <= '0;
      lev_r   <= '0;
      eds_r   <= '0;
      ren_r   <= '0;
      fen_r   <= '0;
      hen_r   <= '0;
      len_r   <= '0;
      pud_r   <= '0;
    end else begin
      for (int i = 0; i < PINS; i++) begin
        fsel_r[i] <= fsel_nxt[i];
        pull_r[i] <= pull_nxt[i];
      end
      latch_r <= latch_nxt;
      lev_r   <= lev_nxt;
      eds_r   <= eds_nxt;
      ren_r   <= ren_nxt;
      fen_r   <= fen_nxt;
      hen_r   <= hen_nxt;
      len_r   <= len_nxt;
      pud_r   <= pud_nxt;
    end
  end

endmodule
